[hw/rtl/pcrb_pkg.sv]
// Shared types, constants and helpers for the packet coalescing ring buffer.
// Used by pcrb_ctrl, pcrb_dp and the packet_coalescing_ring_buffer top level.
package pcrb_pkg;

    localparam int RING_BYTES   = 8192;
    localparam int MARKER_BYTES = 4;
    localparam int STORE_DEPTH  = RING_BYTES + MARKER_BYTES;
    localparam int PW           = $clog2(STORE_DEPTH + MARKER_BYTES + 1);
    localparam int SW           = PW + 3;
    localparam int CW           = 12;
    localparam int LW           = 11;
    localparam int RLW          = 12;

    localparam logic [CW-1:0] COAL_RESET = CW'(1200);
    localparam logic [CW-1:0] THR_RESET  = CW'(1024);

    localparam logic [1:0] FUNC_BYTE  = 2'd0;
    localparam logic [1:0] FUNC_FLUSH = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;
    localparam logic [1:0] FUNC_NONE  = 2'd3;

    localparam logic [2:0] ST_STORED   = 3'd0;
    localparam logic [2:0] ST_REJECTED = 3'd1;
    localparam logic [2:0] ST_BYTE_OUT = 3'd2;
    localparam logic [2:0] ST_NO_DATA  = 3'd3;
    localparam logic [2:0] ST_SKIPPED  = 3'd4;
    localparam logic [2:0] ST_DROPPED  = 3'd5;
    localparam logic [2:0] ST_FLUSHED  = 3'd6;

    localparam logic CFG_COAL = 1'b0;
    localparam logic CFG_THR  = 1'b1;

    typedef struct packed {
        logic [1:0]    func;
        logic          msg_start;
        logic [LW-1:0] msg_len;
        logic [7:0]    data_byte;
    } t_in;

    typedef struct packed {
        logic [2:0]    status;
        logic [7:0]    out_byte;
        logic          last_of_packet;
        logic [PW-1:0] store_addr;
    } t_out;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_RSV_TAKE,
        OP_WRITE,
        OP_EP_FLUSH,
        OP_EP_WRAP,
        OP_EP_MARK,
        OP_EP_PEND,
        OP_MK_WR,
        OP_MK_WR_FIN,
        OP_RD_INIT,
        OP_MK_RD,
        OP_RD_EVAL,
        OP_RD_BYTE,
        OP_RD_CAP,
        OP_RD_CAP3,
        OP_RD_LAST
    } t_op;

    typedef struct packed {
        logic       accept;
        t_op        op;
        logic       emit;
        logic [2:0] status;
    } t_cmd;

    typedef struct packed {
        logic [1:0] func;
        logic       msg_start;
        logic       len_zero;
        logic       open_zero;
        logic       open_one;
        logic       over_limit;
        logic       rsv_ok;
        logic       pe_ne_cp;
        logic       ep_wrap;
        logic       ep_small;
        logic       ep_commit;
        logic       k_last;
        logic       rl_zero;
        logic       rp_eq_cp;
        logic       mk_small;
    } t_sts;

    // Reduces an offset below twice the store depth into the store.
    function automatic logic [PW-1:0] ring_at(input logic [PW:0] x);
        logic [PW:0] r;
        begin
            if (x >= (PW+1)'(STORE_DEPTH)) begin
                r = x - (PW+1)'(STORE_DEPTH);
            end else begin
                r = x;
            end
            return r[PW-1:0];
        end
    endfunction

endpackage

[hw/rtl/pcrb_ctrl.sv]
// Controller state machine of the packet coalescing ring buffer.
// Depends on pcrb_pkg; drives pcrb_dp through command and status structs.
module pcrb_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  pcrb_pkg::t_sts i_sts,
    output pcrb_pkg::t_cmd o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_DISP, S_RSV0, S_RSV2, S_WR, S_FLUSH, S_EP_TEST, S_MKW_WRAP,
        S_EP_SIZE, S_MKW_SIZE, S_RD, S_MKR, S_MKR_END, S_RD_EVAL, S_RDB,
        S_RDC, S_RDL
    } t_state;

    typedef enum logic [1:0] {RET_RSV, RET_REJ, RET_FLUSH, RET_STORE} t_ret;

    t_state r_state, n_state;
    t_ret   r_ret, n_ret;
    logic   do_ret;

    assign busy = (r_state != S_IDLE);

    always_comb begin
        n_state      = r_state;
        n_ret        = r_ret;
        do_ret       = 1'b0;
        o_cmd        = '0;
        o_cmd.op     = pcrb_pkg::OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_DISP;
                end
            end
            S_DISP: begin
                case (i_sts.func)
                    pcrb_pkg::FUNC_BYTE: begin
                        if (i_sts.msg_start) begin
                            if (i_sts.len_zero) begin
                                o_cmd.emit   = 1'b1;
                                o_cmd.status = pcrb_pkg::ST_DROPPED;
                                n_state      = S_IDLE;
                            end else begin
                                n_state = S_RSV0;
                            end
                        end else if (i_sts.open_zero) begin
                            o_cmd.emit   = 1'b1;
                            o_cmd.status = pcrb_pkg::ST_DROPPED;
                            n_state      = S_IDLE;
                        end else begin
                            n_state = S_WR;
                        end
                    end
                    pcrb_pkg::FUNC_FLUSH: begin
                        n_ret   = RET_FLUSH;
                        n_state = S_FLUSH;
                    end
                    pcrb_pkg::FUNC_READ: begin
                        n_state = S_RD;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_RSV0: begin
                if (i_sts.over_limit) begin
                    n_ret   = RET_RSV;
                    n_state = S_FLUSH;
                end else begin
                    n_state = S_RSV2;
                end
            end
            S_RSV2: begin
                if (i_sts.rsv_ok) begin
                    o_cmd.op = pcrb_pkg::OP_RSV_TAKE;
                    n_state  = S_WR;
                end else begin
                    n_ret   = RET_REJ;
                    n_state = S_FLUSH;
                end
            end
            S_WR: begin
                o_cmd.op = pcrb_pkg::OP_WRITE;
                if (i_sts.open_one) begin
                    n_ret   = RET_STORE;
                    n_state = S_EP_TEST;
                end else begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.status = pcrb_pkg::ST_STORED;
                    n_state      = S_IDLE;
                end
            end
            S_FLUSH: begin
                if (i_sts.pe_ne_cp) begin
                    o_cmd.op = pcrb_pkg::OP_EP_FLUSH;
                    n_state  = S_EP_TEST;
                end else begin
                    do_ret = 1'b1;
                end
            end
            S_EP_TEST: begin
                if (i_sts.ep_wrap) begin
                    o_cmd.op = pcrb_pkg::OP_EP_WRAP;
                    n_state  = S_MKW_WRAP;
                end else begin
                    n_state = S_EP_SIZE;
                end
            end
            S_MKW_WRAP: begin
                o_cmd.op = pcrb_pkg::OP_MK_WR;
                if (i_sts.k_last) begin
                    n_state = S_EP_SIZE;
                end
            end
            S_EP_SIZE: begin
                if (i_sts.ep_small) begin
                    do_ret = 1'b1;
                end else if (i_sts.ep_commit) begin
                    o_cmd.op = pcrb_pkg::OP_EP_MARK;
                    n_state  = S_MKW_SIZE;
                end else begin
                    o_cmd.op = pcrb_pkg::OP_EP_PEND;
                    do_ret   = 1'b1;
                end
            end
            S_MKW_SIZE: begin
                if (i_sts.k_last) begin
                    o_cmd.op = pcrb_pkg::OP_MK_WR_FIN;
                    do_ret   = 1'b1;
                end else begin
                    o_cmd.op = pcrb_pkg::OP_MK_WR;
                end
            end
            S_RD: begin
                if (!i_sts.rl_zero) begin
                    n_state = S_RDB;
                end else if (i_sts.rp_eq_cp) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.status = pcrb_pkg::ST_NO_DATA;
                    n_state      = S_IDLE;
                end else begin
                    o_cmd.op = pcrb_pkg::OP_RD_INIT;
                    n_state  = S_MKR;
                end
            end
            S_MKR: begin
                o_cmd.op = pcrb_pkg::OP_MK_RD;
                if (i_sts.k_last) begin
                    n_state = S_MKR_END;
                end
            end
            S_MKR_END: begin
                n_state = S_RD_EVAL;
            end
            S_RD_EVAL: begin
                o_cmd.op = pcrb_pkg::OP_RD_EVAL;
                if (i_sts.mk_small) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.status = pcrb_pkg::ST_SKIPPED;
                    n_state      = S_IDLE;
                end else begin
                    n_state = S_RDB;
                end
            end
            S_RDB: begin
                o_cmd.op = pcrb_pkg::OP_RD_BYTE;
                n_state  = S_RDC;
            end
            S_RDC: begin
                if (i_sts.rl_zero) begin
                    o_cmd.op = pcrb_pkg::OP_RD_CAP3;
                    n_state  = S_RDL;
                end else begin
                    o_cmd.op     = pcrb_pkg::OP_RD_CAP;
                    o_cmd.emit   = 1'b1;
                    o_cmd.status = pcrb_pkg::ST_BYTE_OUT;
                    n_state      = S_IDLE;
                end
            end
            S_RDL: begin
                o_cmd.op     = pcrb_pkg::OP_RD_LAST;
                o_cmd.emit   = 1'b1;
                o_cmd.status = pcrb_pkg::ST_BYTE_OUT;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (do_ret) begin
            unique case (r_ret)
                RET_RSV: begin
                    n_state = S_RSV2;
                end
                RET_REJ: begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.status = pcrb_pkg::ST_REJECTED;
                    n_state      = S_IDLE;
                end
                RET_FLUSH: begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.status = pcrb_pkg::ST_FLUSHED;
                    n_state      = S_IDLE;
                end
                RET_STORE: begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.status = pcrb_pkg::ST_STORED;
                    n_state      = S_IDLE;
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= RET_FLUSH;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
        end
    end

endmodule

[hw/rtl/pcrb_dp.sv]
// Datapath of the packet coalescing ring buffer: byte store, ring pointers,
// marker assembly and the result register. Depends on pcrb_pkg.
module pcrb_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pcrb_pkg::t_in                 i_item,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [pcrb_pkg::CW-1:0]       i_cfg_wdata,
    input  pcrb_pkg::t_cmd                i_cmd,
    output pcrb_pkg::t_sts                o_sts,
    output logic                          o_strobe,
    output pcrb_pkg::t_out                o_result
);

    localparam int PW  = pcrb_pkg::PW;
    localparam int SW  = pcrb_pkg::SW;
    localparam int CW  = pcrb_pkg::CW;
    localparam int LW  = pcrb_pkg::LW;
    localparam int RLW = pcrb_pkg::RLW;

    logic [7:0] r_mem [pcrb_pkg::STORE_DEPTH];
    logic [7:0] r_rdata;

    pcrb_pkg::t_in  r_item;
    pcrb_pkg::t_out r_out;
    logic           r_out_valid, n_out_valid;

    logic [CW-1:0]  r_coal, r_thr;
    logic [PW-1:0]  r_rp, n_rp, r_cp, n_cp, r_pe, n_pe, r_oa, n_oa, r_rn, n_rn;
    logic [LW-1:0]  r_ol, n_ol;
    logic [RLW-1:0] r_rl, n_rl;
    logic [PW-1:0]  r_ep_end, n_ep_end, r_mk_at, n_mk_at;
    logic           r_ep_force, n_ep_force, r_ep_wrapped, n_ep_wrapped;
    logic [31:0]    r_mk_val, n_mk_val;
    logic [1:0]     r_k, n_k, r_mk_pk, n_mk_pk;
    logic           r_mk_pend, n_mk_pend;
    logic [7:0]     r_res_byte, n_res_byte;
    logic           r_res_last, n_res_last;
    logic [PW-1:0]  r_res_addr, n_res_addr;

    logic           mem_we, mem_re;
    logic [PW-1:0]  mem_addr;
    logic [7:0]     mem_wdata;

    logic signed [SW-1:0] s_pe, s_cp, s_rp, s_len, s_coal, ws1, avail1, avail2;
    logic           at_end, fit1, fit2;
    logic [PW-1:0]  ws, ep_size, wa, ra, mk_addr, rd_addr, rp3_addr, rp_small;
    logic [31:0]    wrap_diff;
    logic [30:0]    mk_size, rl_diff;

    always_comb begin
        s_pe   = SW'(r_pe);
        s_cp   = SW'(r_cp);
        s_rp   = SW'(r_rp);
        s_len  = SW'(r_item.msg_len);
        s_coal = SW'(r_coal);
        ws1    = s_pe + ((r_pe == r_cp) ? SW'(pcrb_pkg::MARKER_BYTES) : SW'(0));
        at_end = (r_rp <= r_pe);
        avail1 = at_end ? (SW'(pcrb_pkg::RING_BYTES) - ws1) : (s_rp - ws1 - SW'(1));
        avail2 = s_rp - SW'(pcrb_pkg::MARKER_BYTES + 1);
        fit1   = (s_len <= avail1);
        fit2   = (s_len <= avail2);
        ws     = fit1 ? ws1[PW-1:0] : PW'(pcrb_pkg::MARKER_BYTES);

        ep_size   = r_ep_wrapped ? r_ep_end : (r_ep_end - r_cp);
        wrap_diff = 32'(r_pe) - 32'(r_cp);
        wa        = pcrb_pkg::ring_at({1'b0, r_oa});
        ra        = pcrb_pkg::ring_at({1'b0, r_rn});
        mk_addr   = pcrb_pkg::ring_at({1'b0, r_mk_at} + (PW+1)'(r_k));
        rd_addr   = pcrb_pkg::ring_at({1'b0, r_rp} + (PW+1)'(r_k));
        rp3_addr  = pcrb_pkg::ring_at({1'b0, r_rp} + (PW+1)'(3));
        mk_size   = r_mk_val[30:0];
        rl_diff   = mk_size - 31'(pcrb_pkg::MARKER_BYTES);
        rp_small  = r_mk_val[31] ? '0
                  : pcrb_pkg::ring_at({1'b0, r_rp} + (PW+1)'(mk_size[2:0]));

        o_sts.func       = r_item.func;
        o_sts.msg_start  = r_item.msg_start;
        o_sts.len_zero   = (r_item.msg_len == '0);
        o_sts.open_zero  = (r_ol == '0);
        o_sts.open_one   = (r_ol == LW'(1));
        o_sts.over_limit = ((s_pe - s_cp + s_len) > s_coal);
        o_sts.rsv_ok     = fit1 | (at_end & fit2);
        o_sts.pe_ne_cp   = (r_pe != r_cp);
        o_sts.ep_wrap    = (r_ep_end < r_cp);
        o_sts.ep_small   = (ep_size <= PW'(pcrb_pkg::MARKER_BYTES));
        o_sts.ep_commit  = (ep_size > PW'(r_thr)) | r_ep_force | r_ep_wrapped;
        o_sts.k_last     = (r_k == 2'd3);
        o_sts.rl_zero    = (r_rl == '0);
        o_sts.rp_eq_cp   = (r_rp == r_cp);
        o_sts.mk_small   = (mk_size <= 31'(pcrb_pkg::MARKER_BYTES));
    end

    always_comb begin
        n_rp = r_rp;  n_cp = r_cp;  n_pe = r_pe;  n_oa = r_oa;  n_rn = r_rn;
        n_ol = r_ol;  n_rl = r_rl;
        n_ep_end = r_ep_end;  n_ep_force = r_ep_force;  n_ep_wrapped = r_ep_wrapped;
        n_mk_at = r_mk_at;  n_mk_val = r_mk_val;  n_k = r_k;
        n_mk_pk = r_mk_pk;  n_mk_pend = 1'b0;
        n_res_byte = r_res_byte;  n_res_last = r_res_last;  n_res_addr = r_res_addr;
        mem_we = 1'b0;  mem_re = 1'b0;  mem_addr = '0;  mem_wdata = '0;

        if (r_mk_pend) begin
            n_mk_val[8*r_mk_pk +: 8] = r_rdata;
        end

        if (i_cmd.accept) begin
            n_res_byte = '0;
            n_res_last = 1'b0;
            n_res_addr = '0;
            if (i_item.func == pcrb_pkg::FUNC_FLUSH ||
                (i_item.func == pcrb_pkg::FUNC_BYTE && i_item.msg_start)) begin
                n_ol = '0;
            end
        end

        case (i_cmd.op)
            pcrb_pkg::OP_RSV_TAKE: begin
                n_oa = ws;
                n_ol = r_item.msg_len;
            end
            pcrb_pkg::OP_WRITE: begin
                mem_we       = 1'b1;
                mem_addr     = wa;
                mem_wdata    = r_item.data_byte;
                n_res_addr   = wa;
                n_oa         = wa + PW'(1);
                n_ol         = r_ol - LW'(1);
                n_ep_end     = wa + PW'(1);
                n_ep_force   = 1'b0;
                n_ep_wrapped = 1'b0;
            end
            pcrb_pkg::OP_EP_FLUSH: begin
                n_ep_end     = r_pe;
                n_ep_force   = 1'b1;
                n_ep_wrapped = 1'b0;
            end
            pcrb_pkg::OP_EP_WRAP: begin
                n_mk_at      = r_cp;
                n_mk_val     = {1'b1, wrap_diff[30:0]};
                n_k          = '0;
                n_ep_wrapped = 1'b1;
            end
            pcrb_pkg::OP_EP_MARK: begin
                n_mk_at  = r_ep_wrapped ? '0 : r_cp;
                n_mk_val = 32'(ep_size);
                n_k      = '0;
            end
            pcrb_pkg::OP_EP_PEND: begin
                n_pe = r_ep_end;
            end
            pcrb_pkg::OP_MK_WR: begin
                mem_we    = 1'b1;
                mem_addr  = mk_addr;
                mem_wdata = r_mk_val[8*r_k +: 8];
                n_k       = r_k + 2'd1;
            end
            pcrb_pkg::OP_MK_WR_FIN: begin
                mem_we    = 1'b1;
                mem_addr  = mk_addr;
                mem_wdata = r_mk_val[8*r_k +: 8];
                n_k       = r_k + 2'd1;
                n_cp      = r_ep_end;
                n_pe      = r_ep_end;
            end
            pcrb_pkg::OP_RD_INIT: begin
                n_k = '0;
            end
            pcrb_pkg::OP_MK_RD: begin
                mem_re    = 1'b1;
                mem_addr  = rd_addr;
                n_k       = r_k + 2'd1;
                n_mk_pend = 1'b1;
                n_mk_pk   = r_k;
            end
            pcrb_pkg::OP_RD_EVAL: begin
                if (o_sts.mk_small) begin
                    n_rp = rp_small;
                end else begin
                    n_rl = rl_diff[RLW-1:0];
                    n_rn = r_rp + PW'(pcrb_pkg::MARKER_BYTES);
                end
            end
            pcrb_pkg::OP_RD_BYTE: begin
                mem_re     = 1'b1;
                mem_addr   = ra;
                n_res_addr = ra;
                n_rn       = ra + PW'(1);
                n_rl       = r_rl - RLW'(1);
            end
            pcrb_pkg::OP_RD_CAP: begin
                n_res_byte = r_rdata;
            end
            pcrb_pkg::OP_RD_CAP3: begin
                n_res_byte = r_rdata;
                mem_re     = 1'b1;
                mem_addr   = rp3_addr;
            end
            pcrb_pkg::OP_RD_LAST: begin
                n_res_last = 1'b1;
                n_rp       = r_rdata[7] ? '0 : pcrb_pkg::ring_at({1'b0, r_rn});
            end
            default: begin
            end
        endcase
        n_out_valid = i_cmd.emit;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coal      <= pcrb_pkg::COAL_RESET;
            r_thr       <= pcrb_pkg::THR_RESET;
            r_rp        <= '0;
            r_cp        <= '0;
            r_pe        <= PW'(pcrb_pkg::MARKER_BYTES);
            r_oa        <= '0;
            r_ol        <= '0;
            r_rl        <= '0;
            r_rn        <= '0;
            r_mk_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    pcrb_pkg::CFG_COAL: r_coal <= i_cfg_wdata;
                    pcrb_pkg::CFG_THR:  r_thr  <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
            r_rp        <= n_rp;
            r_cp        <= n_cp;
            r_pe        <= n_pe;
            r_oa        <= n_oa;
            r_ol        <= n_ol;
            r_rl        <= n_rl;
            r_rn        <= n_rn;
            r_mk_pend   <= n_mk_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_item <= i_item;
        end
        r_ep_end     <= n_ep_end;
        r_ep_force   <= n_ep_force;
        r_ep_wrapped <= n_ep_wrapped;
        r_mk_at      <= n_mk_at;
        r_mk_val     <= n_mk_val;
        r_k          <= n_k;
        r_mk_pk      <= n_mk_pk;
        r_res_byte   <= n_res_byte;
        r_res_last   <= n_res_last;
        r_res_addr   <= n_res_addr;
        if (i_cmd.emit) begin
            r_out.status         <= i_cmd.status;
            r_out.out_byte       <= n_res_byte;
            r_out.last_of_packet <= n_res_last;
            r_out.store_addr     <= n_res_addr;
        end
    end

    assign o_strobe = r_out_valid;
    assign o_result = r_out;

endmodule

[hw/rtl/packet_coalescing_ring_buffer.sv]
// Top level of the packet coalescing ring buffer.
// Depends on pcrb_pkg, pcrb_ctrl and pcrb_dp.
//
// A command word on i_item is taken at a clock edge where start is high and
// busy is low: a message byte, a flush of the pending packet or a read of
// one payload byte. Every command except the no-op code returns one result
// word on o_result, marked by o_strobe for a single cycle; the receiver
// cannot hold it off. The next command may be presented in that same cycle.
// Registers coalesce_limit and push_threshold are written through i_cfg_we,
// i_cfg_idx and i_cfg_wdata, one write per cycle. The user must write them
// only while the block is idle; the block itself does not enforce this.
// Everything goes through one single-port byte memory with a registered
// read, so the cycle count follows the number of memory accesses.
// A first message byte first checks and reserves room in the ring, and on
// the read side the last byte of a packet takes one more memory read for
// the flag byte of its marker. Closing a packet writes its 4-byte size
// markers, a message over the coalescing limit first flushes and closes the
// pending packet, and opening a packet on the read side fetches its marker.
// Synchronous reset empties the ring and restores the register defaults;
// the store contents are not cleared and need no clearing pass.
module packet_coalescing_ring_buffer (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  pcrb_pkg::t_in           i_item,
    output logic                    o_strobe,
    output pcrb_pkg::t_out          o_result,
    input  logic                    i_cfg_we,
    input  logic                    i_cfg_idx,
    input  logic [pcrb_pkg::CW-1:0] i_cfg_wdata
);

    pcrb_pkg::t_cmd cmd;
    pcrb_pkg::t_sts sts;

    pcrb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    pcrb_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_strobe    (o_strobe),
        .o_result    (o_result)
    );

    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result word without a command in progress");

    a_accept_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not start work");

    a_last_only_on_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.last_of_packet) |-> o_result.status == pcrb_pkg::ST_BYTE_OUT)
        else $error("end of packet flag on a word that is not a read byte");

    a_emit_only_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> busy && !cmd.accept)
        else $error("result issued outside a command");

endmodule
